/* rtl/core/multi_key_debounce_long_press_macros.svh */
// Assertion macros shared by the key debouncer RTL.
// No dependencies; include with the bare file name inside a module body.
`ifndef MULTI_KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define MULTI_KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Invariant that must hold at every clock edge outside reset.
`define MKDLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define MKDLP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/mkdlp_pkg.sv */
// Package for the key debouncer: key counts, codes, event/phase types, word structs.
// No dependencies; used by the interfaces, the lane, the merge and the top level.
`timescale 1ns / 1ps

package mkdlp_pkg;

  localparam int NPINS          = 5;
  localparam int NKEYS          = 6;
  localparam int COMBO          = 5;
  localparam int COUNT_BITS_DEF = 8;
  localparam int CODE_W         = 3;
  localparam int CFG_W          = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int DELAY_W        = 8;

  // key codes reported by a read
  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
  localparam logic [CODE_W-1:0] CODE_LONG = 3'd6;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_ENABLE  = 2'd0,
    CFG_PRESS_LEVEL = 2'd1,
    CFG_LONG_DELAY  = 2'd2
  } cfg_idx_t;

  // per-key phase machine, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_CONFIRM = 4'b0010,
    PH_DOWN    = 4'b0100,
    PH_HELD    = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } evt_t;

  // lane status toward the merge stage
  typedef struct packed {
    logic pressed_nxt;  // pressed bit after this item
    evt_t evt_nxt;      // event after this item, combo override included
    evt_t evt_cur;      // registered event, seen by a read
    logic held_fin;     // key is held after this item
  } lane_stat_t;

  // result word
  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [NKEYS-1:0]  held_mask;
  } out_word_t;

endpackage

/* rtl/core/mkdlp_if.sv */
// Valid/ready channel interfaces for the key debouncer input and result words.
// Depends on mkdlp_pkg.
`timescale 1ns / 1ps

interface mkdlp_in_if;
  import mkdlp_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [NPINS-1:0] pins;

  modport source (output valid, output cmd, output pins, input ready);
  modport sink   (input valid, input cmd, input pins, output ready);
endinterface

interface mkdlp_out_if;
  import mkdlp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic [NKEYS-1:0]  held_mask;

  modport source (output valid, output key_code, output held_mask, input ready);
  modport sink   (input valid, input key_code, input held_mask, output ready);
endinterface

/* rtl/core/mkdlp_lane.sv */
// One key lane: pressed bit, four-phase debounce machine, event, combo hold counter.
// Depends on mkdlp_pkg; instantiated six times by the top level.
`timescale 1ns / 1ps

module mkdlp_lane #(
  parameter bit IS_COMBO   = 1'b0,
  parameter int COUNT_BITS = mkdlp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          scan,        // accepted scan word
  input  logic                          clr,         // accepted read clears this event
  input  logic                          level,
  input  logic                          enable,
  input  logic                          plevel,
  input  logic                          force_idle,  // combo override, scans only
  input  logic [mkdlp_pkg::DELAY_W-1:0] long_delay,
  output mkdlp_pkg::lane_stat_t         stat
);
  import mkdlp_pkg::*;

  phase_t phase_r, phase_nxt, phase_scan;
  evt_t   evt_r, evt_nxt, evt_scan;
  logic   pressed_r, pressed_nxt;
  logic   fire;

  // sample only while enabled
  assign pressed_nxt = (scan && enable) ? (level == plevel) : pressed_r;

  // phase machine on a scan
  always_comb begin
    phase_scan = phase_r;
    evt_scan   = EV_NONE;
    unique case (phase_r)
      PH_IDLE: begin
        if (pressed_nxt) phase_scan = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        phase_scan = pressed_nxt ? PH_DOWN : PH_IDLE;
      end
      PH_DOWN: begin
        if (pressed_nxt) begin
          phase_scan = PH_HELD;
          evt_scan   = EV_PRESS;
        end else begin
          phase_scan = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!pressed_nxt) begin
          phase_scan = PH_IDLE;
          evt_scan   = EV_RELEASE;
        end else if (fire) begin
          evt_scan = EV_LONG;
        end
      end
      default: begin
        phase_scan = PH_IDLE;
      end
    endcase
  end

  // pick scan result, read clear, or hold; then the override
  always_comb begin
    phase_nxt = phase_r;
    evt_nxt   = evt_r;
    if (scan) begin
      phase_nxt = phase_scan;
      evt_nxt   = evt_scan;
      if (force_idle) begin
        phase_nxt = PH_IDLE;
        evt_nxt   = EV_NONE;
      end
    end else if (clr) begin
      evt_nxt = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      evt_r     <= EV_NONE;
      pressed_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      evt_r     <= evt_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  // hold counter exists only in the combo lane
  generate
    if (IS_COMBO) begin : g_cnt
      localparam int CMP_W = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;
      localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

      logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;

      // saturating increment
      assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
      assign fire    = CMP_W'(cnt_inc) >= CMP_W'(long_delay);

      always_comb begin
        cnt_nxt = cnt_r;
        if (scan && pressed_nxt) begin
          if (phase_r == PH_CONFIRM) cnt_nxt = '0;
          else if (phase_r == PH_HELD) cnt_nxt = fire ? '0 : cnt_inc;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) cnt_r <= '0;
        else        cnt_r <= cnt_nxt;
      end
    end else begin : g_nocnt
      assign fire = 1'b0;
    end
  endgenerate

  // status toward the merge stage
  assign stat.pressed_nxt = pressed_nxt;
  assign stat.evt_nxt     = evt_nxt;
  assign stat.evt_cur     = evt_r;
  assign stat.held_fin    = (phase_nxt == PH_HELD);

endmodule

/* rtl/core/mkdlp_merge.sv */
// Merge stage: combo override, read priority encoder with event clear, held mask.
// Depends on mkdlp_pkg; combines the six lane status structs.
`timescale 1ns / 1ps

module mkdlp_merge (
  input  logic                                     scan,
  input  logic                                     rd,
  input  mkdlp_pkg::lane_stat_t [mkdlp_pkg::NKEYS-1:0] stat,
  output logic                                     force_idle,
  output logic [mkdlp_pkg::NKEYS-1:0]              clr_vec,
  output logic [mkdlp_pkg::CODE_W-1:0]             key_code,
  output logic [mkdlp_pkg::NKEYS-1:0]              held_mask
);
  import mkdlp_pkg::*;

  logic [CODE_W-1:0] code_sel;
  logic [NKEYS-1:0]  clr_sel;

  // combo pressed or firing blocks its two member keys
  assign force_idle = scan &&
                      (stat[COMBO].pressed_nxt || (stat[COMBO].evt_nxt == EV_LONG));

  // lowest pending release wins, then combo long press
  always_comb begin
    code_sel = CODE_NONE;
    clr_sel  = '0;
    if (stat[COMBO].evt_cur == EV_LONG) begin
      code_sel       = CODE_LONG;
      clr_sel[COMBO] = 1'b1;
    end
    for (int k = NPINS - 1; k >= 0; k--) begin
      if (stat[k].evt_cur == EV_RELEASE) begin
        code_sel = CODE_W'(k + 1);
        clr_sel  = NKEYS'(1) << k;
      end
    end
  end

  assign clr_vec  = rd ? clr_sel : '0;
  assign key_code = rd ? code_sel : CODE_NONE;

  always_comb begin
    for (int k = 0; k < NKEYS; k++) held_mask[k] = stat[k].held_fin;
  end

endmodule

/* rtl/core/multi_key_debounce_long_press.sv */
// Top level of the five-key debouncer with combo key: config registers, six lanes,
// merge stage and output register with skid. Depends on mkdlp_pkg, mkdlp_if, lane, merge.
`timescale 1ns / 1ps

// Takes one word per clock, scans and reads alike, while the skid stage is empty. Each word is handled
// in the cycle it is accepted: six key lanes update side by side and the merge stage applies the combo
// override and the read priority in the same cycle. The result word goes to the output register, or to
// the skid stage while the output word waits; this one-word skid keeps input ready high while a result
// waits, so input stalls only when two results are pending. Events live until the next scan or until
// a read reports them. No clearing pass after reset. Config writes take effect at the next edge.
module multi_key_debounce_long_press #(
  parameter int COUNT_BITS = mkdlp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mkdlp_in_if.sink                        in_if,
  mkdlp_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [mkdlp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mkdlp_pkg::CFG_W-1:0]     cfg_data
);
  import mkdlp_pkg::*;

  `include "multi_key_debounce_long_press_macros.svh"

  logic [NKEYS-1:0]   key_enable_r, press_level_r;
  logic [DELAY_W-1:0] long_delay_r;

  logic               acc, scan, rd, take;
  logic [NKEYS-1:0]   lvl, clr_vec, held_mask;
  logic [CODE_W-1:0]  key_code;
  logic               force_idle;
  lane_stat_t [NKEYS-1:0] stat;
  out_word_t          word_new, out_r, skid_r;
  logic               oval_r, sval_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_enable_r  <= '1;
      press_level_r <= '0;
      long_delay_r  <= DELAY_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KEY_ENABLE:  key_enable_r  <= cfg_data[NKEYS-1:0];
        CFG_PRESS_LEVEL: press_level_r <= cfg_data[NKEYS-1:0];
        CFG_LONG_DELAY:  long_delay_r  <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_if.ready = !sval_r;
  assign acc         = in_if.valid && !sval_r;
  assign scan        = acc && !in_if.cmd;
  assign rd          = acc && in_if.cmd;

  // combo level is low only when pins 1 and 4 are both low
  assign lvl = {in_if.pins[1] | in_if.pins[4], in_if.pins};

  // key lanes
  generate
    for (genvar k = 0; k < NKEYS; k++) begin : g_lane
      mkdlp_lane #(
        .IS_COMBO   (k == COMBO),
        .COUNT_BITS (COUNT_BITS)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .clr        (clr_vec[k]),
        .level      (lvl[k]),
        .enable     (key_enable_r[k]),
        .plevel     (press_level_r[k]),
        .force_idle (force_idle && (k == 1 || k == 4)),
        .long_delay (long_delay_r),
        .stat       (stat[k])
      );
    end
  endgenerate

  mkdlp_merge u_merge (
    .scan       (scan),
    .rd         (rd),
    .stat       (stat),
    .force_idle (force_idle),
    .clr_vec    (clr_vec),
    .key_code   (key_code),
    .held_mask  (held_mask)
  );

  assign word_new.key_code  = key_code;
  assign word_new.held_mask = held_mask;

  // output register plus one-word skid
  assign take = oval_r && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
      sval_r <= 1'b0;
    end else if (!oval_r || take) begin
      oval_r <= sval_r || acc;
      sval_r <= 1'b0;
    end else if (acc) begin
      sval_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!oval_r || take) begin
      out_r <= sval_r ? skid_r : word_new;
    end else if (acc) begin
      skid_r <= word_new;
    end
  end

  assign out_if.valid     = oval_r;
  assign out_if.key_code  = out_r.key_code;
  assign out_if.held_mask = out_r.held_mask;

  // checks
  `MKDLP_ASSERT_IMPLY(a_skid_needs_out, sval_r, oval_r, "skid word without output word")
  `MKDLP_ASSERT_ALWAYS(a_clr_onehot, $onehot0(clr_vec), "read clears more than one event")
  `MKDLP_ASSERT_IMPLY(a_combo_excl, oval_r && out_r.held_mask[COMBO], !out_r.held_mask[1] && !out_r.held_mask[4], "combo held with a member key held")
  `MKDLP_ASSERT_IMPLY(a_scan_no_code, scan, key_code == CODE_NONE, "scan word carries a key code")

endmodule
